### src/chsa_pkg.sv
// Shared constants, types and range-overlap helper for the copy stream hazard assigner.
package chsa_pkg;

    localparam int ADDR_W = 48;
    localparam int SIZE_W = 31;
    localparam int LOG2_W = 2;
    localparam int IDX_W  = 3;
    localparam int CNT_W  = 4;
    localparam int DEP_W  = 5;

    localparam int DEF_MAX_STREAMS = 8;
    localparam int DEF_MAX_ENTRIES = 16;

    // one stored entry: reduce flag, byte count, source, destination
    localparam int ENTRY_W = 1 + SIZE_W + 2 * ADDR_W;

    typedef struct packed {
        logic start;
        logic issue;
        logic commit;
    } chsa_cmd_t;

    typedef struct packed {
        logic open_zero;
        logic last;
        logic out_free;
    } chsa_stat_t;

    // Half-open ranges [a,a+n) and [b,b+m) overlap.
    function automatic logic ranges_meet(input logic [ADDR_W-1:0] a,
                                         input logic [SIZE_W-1:0] n,
                                         input logic [ADDR_W-1:0] b,
                                         input logic [SIZE_W-1:0] m);
        logic [ADDR_W:0] a_end;
        logic [ADDR_W:0] b_end;
        a_end = {1'b0, a} + (ADDR_W + 1)'(n);
        b_end = {1'b0, b} + (ADDR_W + 1)'(m);
        return (a_end > {1'b0, b}) && ({1'b0, a} < b_end);
    endfunction

endpackage

### src/copy_stream_hazard_assigner_top.sv
// Top level of the copy stream hazard assigner: controller, datapath and checks.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | action, dest_addr, src_addr, byte_size, is_reduce
//  m_      | out       | m_valid / m_ready  | stream_index, flushed, flushed_* report
//  cfg_    | in        | cfg_wr_en          | cfg_wr_data = element_size_log2
//
// An item is accepted, then scanned with one memory read per stored entry through
// the single read port of the entry RAM, then drained and committed; an empty table
// skips the scan and drain. Synchronous active-low reset empties the table at once
// (per-stream fill counters); the entry RAM needs no clearing. The result register lets
// a new item in while the last result waits; commit stalls while that result is held.
module copy_stream_hazard_assigner_top #(
    parameter int MAX_STREAMS = chsa_pkg::DEF_MAX_STREAMS,
    parameter int MAX_ENTRIES = chsa_pkg::DEF_MAX_ENTRIES
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [chsa_pkg::LOG2_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [chsa_pkg::ADDR_W-1:0]   s_dest_addr,
    input  logic [chsa_pkg::ADDR_W-1:0]   s_src_addr,
    input  logic [chsa_pkg::SIZE_W-1:0]   s_byte_size,
    input  logic                          s_is_reduce,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [chsa_pkg::IDX_W-1:0]    m_stream_index,
    output logic                          m_flushed,
    output logic [chsa_pkg::CNT_W-1:0]    m_flushed_streams,
    output logic [chsa_pkg::DEP_W-1:0]    m_flushed_depth,
    output logic [chsa_pkg::SIZE_W-1:0]   m_flushed_max_elements
);
    import chsa_pkg::*;

    chsa_cmd_t  cmd;
    chsa_stat_t stat;

    chsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    chsa_dp #(
        .MAX_STREAMS(MAX_STREAMS),
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_dp (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cmd                    (cmd),
        .stat                   (stat),
        .cfg_wr_en              (cfg_wr_en),
        .cfg_wr_data            (cfg_wr_data),
        .s_action               (s_action),
        .s_dest_addr            (s_dest_addr),
        .s_src_addr             (s_src_addr),
        .s_byte_size            (s_byte_size),
        .s_is_reduce            (s_is_reduce),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_stream_index         (m_stream_index),
        .m_flushed              (m_flushed),
        .m_flushed_streams      (m_flushed_streams),
        .m_flushed_depth        (m_flushed_depth),
        .m_flushed_max_elements (m_flushed_max_elements)
    );

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in flight");

    a_report_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_flushed |-> m_flushed_streams == '0 && m_flushed_depth == '0 &&
                                  m_flushed_max_elements == '0)
        else $error("flush report set without a flush");

    a_report_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_flushed |-> m_flushed_streams != '0 && m_flushed_depth != '0)
        else $error("flush reported for an empty table");

endmodule

### src/chsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module chsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/chsa_ctrl.sv
// Controller: sequences accept, table scan, pipeline drain and commit.
module chsa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  chsa_pkg::chsa_stat_t stat,
    output chsa_pkg::chsa_cmd_t  cmd
);
    import chsa_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_DECIDE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    state_next = stat.open_zero ? ST_DECIDE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.issue = 1'b1;
                if (stat.last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE: begin
                // hold until the output register can take the result
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### src/chsa_dp.sv
// Datapath: entry memory, scan counters, hazard and flush accumulators, result register.
module chsa_dp #(
    parameter int MAX_STREAMS = chsa_pkg::DEF_MAX_STREAMS,
    parameter int MAX_ENTRIES = chsa_pkg::DEF_MAX_ENTRIES
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  chsa_pkg::chsa_cmd_t                 cmd,
    output chsa_pkg::chsa_stat_t                stat,
    input  logic                                cfg_wr_en,
    input  logic [chsa_pkg::LOG2_W-1:0]         cfg_wr_data,
    input  logic                                s_action,
    input  logic [chsa_pkg::ADDR_W-1:0]         s_dest_addr,
    input  logic [chsa_pkg::ADDR_W-1:0]         s_src_addr,
    input  logic [chsa_pkg::SIZE_W-1:0]         s_byte_size,
    input  logic                                s_is_reduce,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [chsa_pkg::IDX_W-1:0]          m_stream_index,
    output logic                                m_flushed,
    output logic [chsa_pkg::CNT_W-1:0]          m_flushed_streams,
    output logic [chsa_pkg::DEP_W-1:0]          m_flushed_depth,
    output logic [chsa_pkg::SIZE_W-1:0]         m_flushed_max_elements
);
    import chsa_pkg::*;

    localparam int SLOTS = MAX_STREAMS * MAX_ENTRIES;
    localparam int SW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
    localparam int CW = $clog2(MAX_STREAMS + 1);
    localparam int EW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int FW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // request and configuration
    logic              action_reg;
    logic [ADDR_W-1:0] dest_reg;
    logic [ADDR_W-1:0] src_reg;
    logic [SIZE_W-1:0] bytes_reg;
    logic              reduce_reg;
    logic [LOG2_W-1:0] log2_reg;

    // table bookkeeping
    logic [FW-1:0] fill_reg [MAX_STREAMS];
    logic [CW-1:0] open_reg;

    // scan counters and compare stage
    logic [SW-1:0] s_reg;
    logic [EW-1:0] e_reg;
    logic [AW-1:0] base_reg;
    logic          rv_reg;
    logic [SW-1:0] tag_s_reg;
    logic [EW-1:0] tag_e_reg;
    logic [MAX_STREAMS-1:0] hit_reg;
    logic [FW-1:0]     depth_reg;
    logic [SIZE_W-1:0] maxel_reg;

    // result register
    logic              m_valid_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              fl_reg;
    logic [CNT_W-1:0]  fl_streams_reg;
    logic [DEP_W-1:0]  fl_depth_reg;
    logic [SIZE_W-1:0] fl_maxel_reg;

    logic [ENTRY_W-1:0] rdata;
    logic [ENTRY_W-1:0] wdata;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic               we;

    logic [ADDR_W-1:0] ent_dest;
    logic [ADDR_W-1:0] ent_src;
    logic [SIZE_W-1:0] ent_bytes;
    logic              ent_hit;
    logic [SIZE_W-1:0] ent_el;
    logic [FW-1:0]     ent_cnt;

    logic [FW-1:0] e_inc;
    logic [CW-1:0] s_inc;
    logic          stream_end;

    logic          found;
    logic [SW-1:0] first;
    logic          later;
    logic [FW-1:0] fill_first;
    logic          need_flush;
    logic [SW-1:0] target;
    logic          flush_now;

    chsa_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.issue),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign wdata = {reduce_reg, bytes_reg, src_reg, dest_reg};
    assign {ent_bytes, ent_src, ent_dest} = rdata[ENTRY_W-2:0];

    // scan step
    assign e_inc      = FW'(e_reg) + FW'(1);
    assign s_inc      = CW'(s_reg) + CW'(1);
    assign stream_end = e_inc >= fill_reg[s_reg];
    assign raddr      = base_reg + AW'(e_reg);

    assign stat.open_zero = (open_reg == '0);
    assign stat.last      = stream_end && (s_inc >= open_reg);
    assign stat.out_free  = !m_valid_reg || m_ready;

    // compare stage on registered memory data
    assign ent_hit = ranges_meet(dest_reg, bytes_reg, ent_src, ent_bytes) ||
                     ranges_meet(dest_reg, bytes_reg, ent_dest, ent_bytes) ||
                     ranges_meet(src_reg, bytes_reg, ent_dest, ent_bytes);
    assign ent_el  = ent_bytes >> log2_reg;
    assign ent_cnt = FW'(tag_e_reg) + FW'(1);

    // placement decision
    always_comb begin
        found = 1'b0;
        first = '0;
        later = 1'b0;
        for (int i = MAX_STREAMS - 1; i >= 0; i--) begin
            if (hit_reg[i]) begin
                found = 1'b1;
                first = SW'(i);
            end
        end
        for (int i = 0; i < MAX_STREAMS; i++) begin
            if (hit_reg[i] && (SW'(i) > first)) begin
                later = 1'b1;
            end
        end
    end

    assign fill_first = fill_reg[first];

    always_comb begin
        if (found) begin
            need_flush = later || (fill_first >= FW'(MAX_ENTRIES));
        end else begin
            need_flush = open_reg >= CW'(MAX_STREAMS);
        end
        if (need_flush) begin
            target = '0;
        end else if (found) begin
            target = first;
        end else begin
            target = SW'(open_reg);
        end
    end

    assign flush_now = action_reg ? (open_reg != '0) : need_flush;
    assign we        = cmd.commit && !action_reg;
    assign waddr     = AW'(target) * AW'(MAX_ENTRIES) +
                       (need_flush ? AW'(0) : AW'(fill_reg[target]));

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            action_reg <= s_action;
            dest_reg   <= s_dest_addr;
            src_reg    <= s_src_addr;
            bytes_reg  <= s_byte_size;
            reduce_reg <= s_is_reduce;
        end
        tag_s_reg <= s_reg;
        tag_e_reg <= e_reg;
        if (cmd.commit) begin
            idx_reg        <= action_reg ? IDX_W'(0) : IDX_W'(target);
            fl_reg         <= flush_now;
            fl_streams_reg <= flush_now ? CNT_W'(open_reg) : CNT_W'(0);
            fl_depth_reg   <= flush_now ? DEP_W'(depth_reg) : DEP_W'(0);
            fl_maxel_reg   <= flush_now ? maxel_reg : SIZE_W'(0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log2_reg    <= '0;
            open_reg    <= '0;
            s_reg       <= '0;
            e_reg       <= '0;
            base_reg    <= '0;
            rv_reg      <= 1'b0;
            hit_reg     <= '0;
            depth_reg   <= '0;
            maxel_reg   <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_STREAMS; i++) begin
                fill_reg[i] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                log2_reg <= cfg_wr_data;
            end
            rv_reg <= cmd.issue;
            if (cmd.start) begin
                s_reg     <= '0;
                e_reg     <= '0;
                base_reg  <= '0;
                hit_reg   <= '0;
                depth_reg <= '0;
                maxel_reg <= '0;
            end else if (cmd.issue) begin
                if (stream_end) begin
                    e_reg    <= '0;
                    s_reg    <= s_reg + SW'(1);
                    base_reg <= base_reg + AW'(MAX_ENTRIES);
                end else begin
                    e_reg <= e_reg + EW'(1);
                end
            end
            if (rv_reg) begin
                if (ent_hit) begin
                    hit_reg[tag_s_reg] <= 1'b1;
                end
                if (ent_cnt > depth_reg) begin
                    depth_reg <= ent_cnt;
                end
                if (ent_el > maxel_reg) begin
                    maxel_reg <= ent_el;
                end
            end
            if (cmd.commit) begin
                if (action_reg) begin
                    open_reg <= '0;
                    for (int i = 0; i < MAX_STREAMS; i++) begin
                        fill_reg[i] <= '0;
                    end
                end else if (need_flush) begin
                    open_reg <= CW'(1);
                    for (int i = 0; i < MAX_STREAMS; i++) begin
                        fill_reg[i] <= (i == 0) ? FW'(1) : FW'(0);
                    end
                end else begin
                    fill_reg[target] <= fill_reg[target] + FW'(1);
                    if (!found) begin
                        open_reg <= open_reg + CW'(1);
                    end
                end
            end
            // drop the result once taken, load a new one on commit
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid                = m_valid_reg;
    assign m_stream_index         = idx_reg;
    assign m_flushed              = fl_reg;
    assign m_flushed_streams      = fl_streams_reg;
    assign m_flushed_depth        = fl_depth_reg;
    assign m_flushed_max_elements = fl_maxel_reg;

endmodule
